/* rtl/sgvs_pkg.sv */
// ----------------------------------------------------------------------------
// sgvs_pkg
// Shared types and defaults of the smoothing group vertex splitter.
// ----------------------------------------------------------------------------
package sgvs_pkg;

   localparam int DEF_ORIGINAL_VERTICES = 1024;
   localparam int DEF_MAX_SPLITS        = 8;
   localparam int DEF_OUTPUT_VERTICES   = 4096;

   localparam int GROUP_W  = 64;
   localparam int VOUT_W   = 12;

   typedef struct packed {
      logic [15:0]        face_id;
      logic [GROUP_W-1:0] face_groups;
      logic [9:0]         original_vertex;
   } req_type;

   typedef struct packed {
      logic [15:0]       face_tag;
      logic [VOUT_W-1:0] vertex_out;
      logic              created;
      logic              overflow;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_LIST_RD,
      ST_ENTRY_RD,
      ST_TEST,
      ST_CREATE,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic clear_en;
      logic load_item;
      logic latch_vtx;
      logic reject;
      logic list_read;
      logic entry_read;
      logic hit;
      logic advance;
      logic create;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic out_of_range;
      logic seen_hit;
      logic match;
      logic scan_last;
      logic clear_last;
      logic rsp_free;
   } status_type;

endpackage

/* rtl/sgvs_ram.sv */
// ----------------------------------------------------------------------------
// sgvs_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sgvs_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/sgvs_ctrl.sv */
// ----------------------------------------------------------------------------
// sgvs_ctrl
// Sequencer: clearing pass, record lookup, split list scan, creation, result.
// ----------------------------------------------------------------------------
module sgvs_ctrl import sgvs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:    if (status.clear_last) state_in = ST_IDLE;
         ST_IDLE:     if (req_valid) state_in = ST_LOOKUP;
         ST_LOOKUP: begin
            if (status.out_of_range) state_in = ST_RESULT;
            else if (status.seen_hit) state_in = ST_LIST_RD;
            else state_in = ST_CREATE;
         end
         ST_LIST_RD:  state_in = ST_ENTRY_RD;
         ST_ENTRY_RD: state_in = ST_TEST;
         ST_TEST: begin
            if (status.match) state_in = ST_RESULT;
            else if (status.scan_last) state_in = ST_CREATE;
            else state_in = ST_LIST_RD;
         end
         ST_CREATE:   state_in = ST_RESULT;
         ST_RESULT:   if (status.rsp_free) state_in = ST_IDLE;
         default:     state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_CLEAR:    cmd.clear_en = 1'b1;
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load_item = req_valid;
         end
         ST_LOOKUP: begin
            if (status.out_of_range) cmd.reject = 1'b1;
            else cmd.latch_vtx = 1'b1;
         end
         ST_LIST_RD:  cmd.list_read = 1'b1;
         ST_ENTRY_RD: cmd.entry_read = 1'b1;
         ST_TEST: begin
            if (status.match) cmd.hit = 1'b1;
            else if (!status.scan_last) cmd.advance = 1'b1;
         end
         ST_CREATE:   cmd.create = 1'b1;
         ST_RESULT:   cmd.emit = status.rsp_free;
         default:     cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/sgvs_datapath.sv */
// ----------------------------------------------------------------------------
// sgvs_datapath
// Vertex records, split lists, split vertex masks and the result register.
// ----------------------------------------------------------------------------
module sgvs_datapath import sgvs_pkg::*; #(
   parameter int ORIGINAL_VERTICES = DEF_ORIGINAL_VERTICES,
   parameter int MAX_SPLITS        = DEF_MAX_SPLITS,
   parameter int OUTPUT_VERTICES   = DEF_OUTPUT_VERTICES
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output status_type status,
   input  req_type    req_payload,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output rsp_type    rsp_payload
);

   localparam int OV_W    = $clog2(ORIGINAL_VERTICES);
   localparam int CNT_W   = $clog2(MAX_SPLITS + 1);
   localparam int VTX_W   = $clog2(OUTPUT_VERTICES);
   localparam int TOT_W   = $clog2(OUTPUT_VERTICES + 1);
   localparam int LIST_D  = ORIGINAL_VERTICES * MAX_SPLITS;
   localparam int LIST_AW = $clog2(LIST_D);
   localparam int REC_W   = GROUP_W + CNT_W;

   req_type            item_ff, item_in;
   logic [OV_W-1:0]    v_ff, v_in;
   logic [GROUP_W-1:0] seen_ff, seen_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [VTX_W-1:0]   entry_ff, entry_in;
   logic [TOT_W-1:0]   total_ff, total_in;
   logic [OV_W-1:0]    clear_addr_ff, clear_addr_in;
   logic [VTX_W-1:0]   res_vtx_ff, res_vtx_in;
   logic               res_created_ff, res_created_in;
   logic               res_overflow_ff, res_overflow_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [REC_W-1:0]   vtx_q, vtx_wd;
   logic               vtx_we;
   logic [OV_W-1:0]    vtx_wa, vtx_ra;
   logic [VTX_W-1:0]   list_q;
   logic               list_we;
   logic [LIST_AW-1:0] list_wa, list_ra;
   logic [GROUP_W-1:0] vg_q, vg_wd;
   logic               vg_we;
   logic [VTX_W-1:0]   vg_wa;

   logic [31:0]        req_v_ext, item_v_ext, res_vtx_ext;
   logic [GROUP_W-1:0] q_seen;
   logic [CNT_W-1:0]   q_cnt;
   logic               full, store;

   assign req_v_ext   = 32'(req_payload.original_vertex);
   assign item_v_ext  = 32'(item_ff.original_vertex);
   assign vtx_ra      = req_v_ext[OV_W-1:0];
   assign q_seen      = vtx_q[REC_W-1:CNT_W];
   assign q_cnt       = vtx_q[CNT_W-1:0];
   assign full        = (32'(cnt_ff) >= 32'(MAX_SPLITS))
                     || (32'(total_ff) >= 32'(OUTPUT_VERTICES));
   assign store       = cmd.create && !full;
   assign res_vtx_ext = 32'(res_vtx_ff);

   assign status.out_of_range = item_v_ext >= 32'(ORIGINAL_VERTICES);
   assign status.seen_hit     = (|(item_ff.face_groups & q_seen)) && (q_cnt != '0);
   assign status.match        = |(item_ff.face_groups & vg_q);
   assign status.scan_last    = ({1'b0, idx_ff} + (CNT_W + 1)'(1)) == {1'b0, cnt_ff};
   assign status.clear_last   = clear_addr_ff == OV_W'(ORIGINAL_VERTICES - 1);
   assign status.rsp_free     = !rsp_valid_ff || !rsp_stall;

   assign vtx_we = cmd.clear_en || cmd.hit || store;
   assign vtx_wa = cmd.clear_en ? clear_addr_ff : v_ff;
   assign vtx_wd = cmd.clear_en ? '0
                 : {seen_ff | item_ff.face_groups,
                    cmd.hit ? cnt_ff : cnt_ff + CNT_W'(1)};

   assign list_we = store;
   assign list_wa = LIST_AW'(32'(v_ff) * 32'(MAX_SPLITS) + 32'(cnt_ff));
   assign list_ra = LIST_AW'(32'(v_ff) * 32'(MAX_SPLITS) + 32'(idx_ff));

   assign vg_we = cmd.hit || store;
   assign vg_wa = cmd.hit ? entry_ff : total_ff[VTX_W-1:0];
   assign vg_wd = cmd.hit ? (vg_q | item_ff.face_groups) : item_ff.face_groups;

   sgvs_ram #(.WIDTH(REC_W), .DEPTH(ORIGINAL_VERTICES)) u_vtx_ram (
      .clock (clock),
      .we    (vtx_we),
      .waddr (vtx_wa),
      .wdata (vtx_wd),
      .re    (cmd.load_item),
      .raddr (vtx_ra),
      .rdata (vtx_q)
   );

   sgvs_ram #(.WIDTH(VTX_W), .DEPTH(LIST_D)) u_list_ram (
      .clock (clock),
      .we    (list_we),
      .waddr (list_wa),
      .wdata (total_ff[VTX_W-1:0]),
      .re    (cmd.list_read),
      .raddr (list_ra),
      .rdata (list_q)
   );

   sgvs_ram #(.WIDTH(GROUP_W), .DEPTH(OUTPUT_VERTICES)) u_vg_ram (
      .clock (clock),
      .we    (vg_we),
      .waddr (vg_wa),
      .wdata (vg_wd),
      .re    (cmd.entry_read),
      .raddr (list_q),
      .rdata (vg_q)
   );

   always_comb begin
      item_in         = item_ff;
      v_in            = v_ff;
      seen_in         = seen_ff;
      cnt_in          = cnt_ff;
      idx_in          = idx_ff;
      entry_in        = entry_ff;
      total_in        = total_ff;
      clear_addr_in   = clear_addr_ff;
      res_vtx_in      = res_vtx_ff;
      res_created_in  = res_created_ff;
      res_overflow_in = res_overflow_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;

      if (cmd.clear_en) clear_addr_in = clear_addr_ff + OV_W'(1);
      if (cmd.load_item) begin
         item_in = req_payload;
         v_in    = req_v_ext[OV_W-1:0];
      end
      if (cmd.latch_vtx) begin
         seen_in = q_seen;
         cnt_in  = q_cnt;
         idx_in  = '0;
      end
      if (cmd.advance) idx_in = idx_ff + CNT_W'(1);
      if (cmd.entry_read) entry_in = list_q;
      if (cmd.reject) begin
         res_vtx_in      = '0;
         res_created_in  = 1'b0;
         res_overflow_in = 1'b1;
      end
      if (cmd.hit) begin
         res_vtx_in      = entry_ff;
         res_created_in  = 1'b0;
         res_overflow_in = 1'b0;
      end
      if (cmd.create) begin
         res_vtx_in      = full ? '0 : total_ff[VTX_W-1:0];
         res_created_in  = !full;
         res_overflow_in = full;
         if (!full) total_in = total_ff + TOT_W'(1);
      end
      if (cmd.emit) begin
         rsp_in.face_tag   = item_ff.face_id;
         rsp_in.vertex_out = res_vtx_ext[VOUT_W-1:0];
         rsp_in.created    = res_created_ff;
         rsp_in.overflow   = res_overflow_ff;
         rsp_valid_in      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff      <= '0;
         clear_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         total_ff      <= total_in;
         clear_addr_ff <= clear_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      item_ff         <= item_in;
      v_ff            <= v_in;
      seen_ff         <= seen_in;
      cnt_ff          <= cnt_in;
      idx_ff          <= idx_in;
      entry_ff        <= entry_in;
      res_vtx_ff      <= res_vtx_in;
      res_created_ff  <= res_created_in;
      res_overflow_ff <= res_overflow_in;
      rsp_ff          <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* rtl/smooth_group_vertex_splitter.sv */
// ----------------------------------------------------------------------------
// smooth_group_vertex_splitter
// Splits original vertices by smoothing group, one face corner per item.
// ----------------------------------------------------------------------------
// The req channel carries one face corner per item (face tag, 64-bit group
// mask, original vertex); the rsp channel returns one item per corner with
// the split vertex index and the created and overflow flags, in order.
// Both channels use valid/stall; an item moves when valid is high and stall
// is low. One corner is processed at a time.
// Per item: an out of range vertex is rejected in the lookup state; otherwise,
// when the vertex record's seen mask hits the group mask, the split list is
// scanned until a split vertex mask matches, and a new split vertex is created
// when none does. Each scanned entry costs a split list read followed by a
// mask read, both registered RAM reads. The result register is loaded before
// the result state passes it on and the next item can be taken.
// Reset (synchronous) starts a clearing pass over every entry of the vertex
// record RAM; req_stall stays high until it ends.
// When the receiver stalls, the result is held in the output register; the
// block accepts the next item and finishes it, then waits with it until the
// output register frees up.
// ----------------------------------------------------------------------------
module smooth_group_vertex_splitter import sgvs_pkg::*; #(
   parameter int ORIGINAL_VERTICES = DEF_ORIGINAL_VERTICES,
   parameter int MAX_SPLITS        = DEF_MAX_SPLITS,
   parameter int OUTPUT_VERTICES   = DEF_OUTPUT_VERTICES
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   cmd_type    cmd;
   status_type status;

   sgvs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sgvs_datapath #(
      .ORIGINAL_VERTICES (ORIGINAL_VERTICES),
      .MAX_SPLITS        (MAX_SPLITS),
      .OUTPUT_VERTICES   (OUTPUT_VERTICES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

/* rtl/sgvs_checker.sv */
// ----------------------------------------------------------------------------
// sgvs_checker
// Port-level checks of the vertex splitter, bound to the top level.
// ----------------------------------------------------------------------------
module sgvs_checker import sgvs_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled rsp item changed");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("req taken while an item is in flight");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.created && rsp_payload.overflow))
      else $error("created and overflow both set");

   a_overflow_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.overflow |-> rsp_payload.vertex_out == '0)
      else $error("overflow item carries a vertex index");

endmodule

bind smooth_group_vertex_splitter sgvs_checker u_sgvs_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

/* tb/sv/vertex_split_checker.sv */
// ----------------------------------------------------------------------------
// vertex_split_checker
// Watches both channels of the splitter, predicts every result and compares.
// ----------------------------------------------------------------------------
// Each accepted face corner is run through a local copy of the per-vertex
// seen masks, split lists and split vertex masks; the predicted result is
// queued and checked field by field against the next accepted result item.
// ----------------------------------------------------------------------------
module vertex_split_checker import sgvs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_payload,
   output int      mismatches,
   output int      pending,
   output int      vertices_made,
   output int      made_count,
   output int      reuse_count,
   output int      full_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_ORIG  = DEF_ORIGINAL_VERTICES;
   localparam int NUM_SPLIT = DEF_MAX_SPLITS;
   localparam int NUM_OUT   = DEF_OUTPUT_VERTICES;

   logic [GROUP_W-1:0] seen_groups [NUM_ORIG];
   int                 split_count [NUM_ORIG];
   int                 split_list [NUM_ORIG*NUM_SPLIT];
   logic [GROUP_W-1:0] split_groups [NUM_OUT];
   int                 split_total;

   rsp_type            corner_results[$];
   int                 error_total;
   int                 result_index;
   int                 made_total;
   int                 reuse_total;
   int                 full_total;

   assign mismatches  = error_total;
   assign made_count  = made_total;
   assign reuse_count = reuse_total;
   assign full_count  = full_total;

   task automatic report(input string what, input logic [63:0] got,
                         input logic [63:0] want);
      if (error_total < 40)
         $display("%0t ns: ERROR result %0d %s: got %0h, expected %0h",
                  $realtime, result_index, what, got, want);
      error_total++;
   endtask

   function automatic rsp_type split_corner(input req_type c);
      rsp_type            r;
      int                 v;
      int                 cnt;
      int                 e;
      logic [GROUP_W-1:0] m;
      r.face_tag   = c.face_id;
      r.vertex_out = '0;
      r.created    = 1'b0;
      r.overflow   = 1'b1;
      m = c.face_groups;
      v = int'(c.original_vertex);
      if (v >= NUM_ORIG)
         return r;
      cnt = split_count[v];
      if ((m & seen_groups[v]) != '0) begin
         for (int i = 0; i < cnt; i++) begin
            e = split_list[v*NUM_SPLIT + i];
            if (e < NUM_OUT && (m & split_groups[e]) != '0) begin
               split_groups[e] |= m;
               seen_groups[v]  |= m;
               r.vertex_out = VOUT_W'(e);
               r.overflow   = 1'b0;
               return r;
            end
         end
      end
      if (cnt >= NUM_SPLIT || split_total >= NUM_OUT)
         return r;
      split_groups[split_total]      = m;
      split_list[v*NUM_SPLIT + cnt]  = split_total;
      split_count[v]                 = cnt + 1;
      seen_groups[v]                |= m;
      r.vertex_out = VOUT_W'(split_total);
      r.created    = 1'b1;
      r.overflow   = 1'b0;
      split_total++;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < NUM_ORIG; i++) begin
            seen_groups[i] = '0;
            split_count[i] = 0;
         end
         split_total = 0;
         corner_results.delete();
      end else begin
         if (req_valid && !req_stall) begin
            want = split_corner(req_payload);
            corner_results.push_back(want);
            if (want.overflow)
               full_total++;
            else if (want.created)
               made_total++;
            else
               reuse_total++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (corner_results.size() == 0) begin
               report("arrived with nothing expected", rsp_payload, '0);
            end else begin
               want = corner_results.pop_front();
               if (rsp_payload.face_tag !== want.face_tag)
                  report("face_tag", rsp_payload.face_tag, want.face_tag);
               if (rsp_payload.vertex_out !== want.vertex_out)
                  report("vertex_out", rsp_payload.vertex_out, want.vertex_out);
               if (rsp_payload.created !== want.created)
                  report("created", rsp_payload.created, want.created);
               if (rsp_payload.overflow !== want.overflow)
                  report("overflow", rsp_payload.overflow, want.overflow);
            end
            result_index++;
         end
      end
      pending       <= corner_results.size();
      vertices_made <= split_total;
   end

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the smoothing group vertex splitter.
// ----------------------------------------------------------------------------
// Drives directed face corners (zero and full masks, reuse at the first and
// last split list entry, full split list), then random corners over small
// pools of vertices and groups. Both channels idle at random; the checker
// predicts and compares.
// ----------------------------------------------------------------------------
module testbench import sgvs_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   req_type req_payload = '0;
   logic    rsp_stall   = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_payload;

   int mismatches;
   int pending;
   int vertices_made;
   int made_count;
   int reuse_count;
   int full_count;

   int sent = 0;
   int vtx_pool[8];
   int group_pool[10];

   smooth_group_vertex_splitter u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   vertex_split_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload),
      .mismatches    (mismatches),
      .pending       (pending),
      .vertices_made (vertices_made),
      .made_count    (made_count),
      .reuse_count   (reuse_count),
      .full_count    (full_count)
   );

   always #5 clock = ~clock;

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
   end

   initial begin
      #20_000_000;
      $display("Mismatches found");
      $finish;
   end

   task automatic offer(input logic [15:0] id, input logic [63:0] groups,
                        input logic [9:0] vtx);
      int          gap;
      logic [95:0] junk;
      gap = (sent % 90 < 25) ? 0 : $urandom_range(9);
      repeat (gap) begin
         @(negedge clock);
         junk = {$urandom, $urandom, $urandom};
         req_valid   <= 1'b0;
         req_payload <= junk[$bits(req_type)-1:0];
      end
      @(negedge clock);
      req_valid               <= 1'b1;
      req_payload.face_id     <= id;
      req_payload.face_groups <= groups;
      req_payload.original_vertex <= vtx;
      do @(posedge clock); while (!(req_valid && !req_stall));
      sent++;
   endtask

   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending == 0);
   endtask

   function automatic logic [63:0] pick_groups();
      int          r;
      logic [63:0] g;
      r = $urandom_range(99);
      g = '0;
      if (r < 50)
         g[group_pool[$urandom_range(9)]] = 1'b1;
      else if (r < 70) begin
         g[group_pool[$urandom_range(9)]] = 1'b1;
         g[group_pool[$urandom_range(9)]] = 1'b1;
      end else if (r < 78)
         g = '0;
      else if (r < 88)
         g[$urandom_range(63)] = 1'b1;
      else
         g = {$urandom, $urandom};
      return g;
   endfunction

   function automatic logic [9:0] pick_vertex();
      if ($urandom_range(99) < 85)
         return 10'(vtx_pool[$urandom_range(7)]);
      return 10'($urandom_range(1023));
   endfunction

   task automatic refresh_pools;
      foreach (vtx_pool[i])
         vtx_pool[i] = $urandom_range(1023);
      foreach (group_pool[i])
         group_pool[i] = $urandom_range(63);
   endtask

   // hold results at random, with quiet stretches and one long hold-off
   initial begin
      int rsp_seen;
      int gap;
      int hold;
      rsp_seen = 0;
      gap      = 0;
      hold     = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            rsp_seen++;
            gap = (rsp_seen % 100 < 30) ? 0 : $urandom_range(9);
            if (rsp_seen == 150)
               hold = 300;
         end
         @(negedge clock);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else if (gap > 0) begin
            rsp_stall <= 1'b1;
            gap--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      wait (!reset);

      offer(16'h0000, 64'h0, 10'd0);
      offer(16'hffff, 64'h0, 10'd0);
      offer(16'hffff, {64{1'b1}}, 10'd1023);
      offer(16'h1234, 64'h1, 10'd1023);
      offer(16'h8000, 64'h8000_0000_0000_0000, 10'd1023);
      offer(16'h0001, 64'h1, 10'd2);
      offer(16'h0002, 64'h2, 10'd2);
      offer(16'h0003, 64'h3, 10'd2);
      offer(16'h0004, 64'h2, 10'd2);
      for (int i = 0; i < DEF_MAX_SPLITS; i++)
         offer(16'(16'h0100 + i), 64'h1 << i, 10'd3);
      offer(16'h0200, 64'h1 << (DEF_MAX_SPLITS - 1), 10'd3);
      offer(16'h0201, 64'h1 << DEF_MAX_SPLITS, 10'd3);
      offer(16'h0202, 64'h0, 10'd3);
      drain();

      refresh_pools();
      for (int n = 0; n < 600; n++) begin
         if (n % 75 == 74)
            refresh_pools();
         if (n == 300)
            drain();
         offer(16'($urandom_range(16'hffff)), pick_groups(), pick_vertex());
      end
      drain();

      for (int n = 0; n < 20; n++)
         offer(16'($urandom_range(16'hffff)), pick_groups(), pick_vertex());

      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending == 0);
      repeat (40) @(posedge clock);

      $display("Covered %0d corners: %0d new split vertices, %0d reuses, %0d overflows",
               sent, made_count, reuse_count, full_count);
      $display("Split vertex table reached %0d entries; long output hold-off included",
               vertices_made);
      if (mismatches == 0 && pending == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
